// ===== sv/nearest_texel_sampler_srgb_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest texel sampler
// Clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TEXEL_SAMPLER_SRGB_MACROS_SVH
`define NEAREST_TEXEL_SAMPLER_SRGB_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define NTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sampler check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define NTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sampler check failed");

`endif

// ===== sv/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Shared constants, types and the sRGB decode table of the texel sampler.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int MAX_SIDE      = 256;
    localparam int STORE_DEPTH   = 65536;
    localparam int OUT_FRAC_BITS = 16;

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int CHAN_W   = 8;
    localparam int TEXEL_W  = 3 * CHAN_W;
    localparam int COORD_W  = 32;
    localparam int UNIT_W   = 17;
    localparam int PROD_W   = UNIT_W + SIDE_W;
    localparam int OUT_W    = OUT_FRAC_BITS + 1;
    localparam int LUT_DEPTH = 256;
    localparam int CFG_IDX_W = 2;

    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << 16;
    localparam logic [OUT_W-1:0]  OUT_ONE  = OUT_W'(1) << OUT_FRAC_BITS;
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(1);

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic magenta;
    } nts_ctl_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } nts_occ_t;

    typedef logic [OUT_W-1:0] decode_lut_t [LUT_DEPTH];

    // sRGB byte to linear Q1.OUT_FRAC_BITS, rounded to nearest, ties upward
    function automatic decode_lut_t build_decode_lut();
        decode_lut_t lut;
        longint      one;
        longint      num;
        real         s;
        real         r;
        one = longint'(1) << OUT_FRAC_BITS;
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            if (i * 100000 <= 4045 * 255)
            begin
                num    = longint'(i) * 10 * one;
                lut[i] = OUT_W'((2 * num + 32946) / 65892);
            end
            else
            begin
                s      = (1000.0 * i + 14025.0) / 269025.0;
                r      = $pow(s, 2.4) * real'(one);
                lut[i] = OUT_W'($rtoi($floor(r + 0.5)));
            end
        end
        return lut;
    endfunction

    localparam decode_lut_t DECODE_LUT = build_decode_lut();

endpackage

// ===== sv/nearest_texel_sampler_srgb.sv =====
// ----------------------------------------------------------------------------
// nearest_texel_sampler_srgb
// Nearest-neighbour RGB8 texture sampler with sRGB to linear Q1.16 decode.
// ----------------------------------------------------------------------------
// A write item (op = 0) transfers one sRGB texel into the 64K-entry store;
// busy stays low, so the next item may follow at once. A sample item
// (op = 1) runs through a five-stage path (clamp, scale and clamp to the
// texture edge, row-major index, store read, table decode). Its result_valid
// strobe rises once the sample has left the decode stage, and
// linear_red/green/blue then stay on the ports until the next sample. Busy
// holds high while a sample is in the path, so a new item cannot start until
// the result strobe; the address pipeline and the single read port of the
// store set this limit. The receiver cannot stall: sample the result in the
// strobe cycle or lose it. With a zero width or height a sample answers
// magenta. The store has no clearing pass: sample only texels that were
// written. Write tex_width / tex_height through the cfg channel (always
// ready) only while the block is idle; values above 256 saturate to 256.
// ----------------------------------------------------------------------------
module nearest_texel_sampler_srgb
    import nts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic [ADDR_W-1:0]         texel_index,
    input  logic [CHAN_W-1:0]         texel_red,
    input  logic [CHAN_W-1:0]         texel_green,
    input  logic [CHAN_W-1:0]         texel_blue,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [SIDE_W-1:0]         cfg_data,
    output logic                      result_valid,
    output logic [OUT_W-1:0]          linear_red,
    output logic [OUT_W-1:0]          linear_green,
    output logic [OUT_W-1:0]          linear_blue
);

`include "nearest_texel_sampler_srgb_macros.svh"

    logic [SIDE_W-1:0]  width_reg, width_next;
    logic [SIDE_W-1:0]  height_reg, height_next;
    logic [SIDE_W-1:0]  cfg_sat;
    logic               item_go;
    logic               sample_go;
    logic               wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [TEXEL_W-1:0] wr_data_reg;
    nts_ctl_t           idx_ctl;
    logic [ADDR_W-1:0]  idx;
    nts_occ_t           occ;
    nts_ctl_t           rd_ctl_reg;
    logic [TEXEL_W-1:0] rd_texel;

    // an item transfers when start meets an idle block
    assign item_go   = start && !busy;
    assign sample_go = item_go && (op == OP_SAMPLE);
    assign busy      = occ.s1 || occ.s2 || occ.s3 || rd_ctl_reg.valid;

    // configuration: always ready, saturate oversized sides
    assign cfg_ready = 1'b1;
    assign cfg_sat   = (cfg_data > SIDE_MAX) ? SIDE_MAX : cfg_data;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH:  width_next  = cfg_sat;
                REG_TEX_HEIGHT: height_next = cfg_sat;
                default:        ;
            endcase
        end
    end

    // register the texel write; the store writes it from these registers,
    // well ahead of any sample read that follows
    assign wr_en_next = item_go && (op == OP_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            wr_en_reg  <= 1'b0;
            rd_ctl_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            wr_en_reg  <= wr_en_next;
            rd_ctl_reg <= idx_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_next)
        begin
            wr_addr_reg <= texel_index;
            wr_data_reg <= {texel_red, texel_green, texel_blue};
        end
    end

    nts_addr_gen u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_go  (sample_go),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .tex_width  (width_reg),
        .tex_height (height_reg),
        .idx_ctl    (idx_ctl),
        .idx        (idx),
        .occ        (occ)
    );

    nts_texel_ram u_texel_ram (
        .clk     (clk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_en   (idx_ctl.valid && !idx_ctl.magenta),
        .rd_addr (idx),
        .rd_data (rd_texel)
    );

    nts_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (rd_ctl_reg),
        .texel        (rd_texel),
        .result_valid (result_valid),
        .linear_red   (linear_red),
        .linear_green (linear_green),
        .linear_blue  (linear_blue)
    );

    // one sample in flight at most
    `NTS_ASSERT_SAME(a_single_flight, clk, rst_n, 1'b1,
        $onehot0({occ.s1, occ.s2, occ.s3, rd_ctl_reg.valid}))
    // a sample start closes the start window on the next cycle
    `NTS_ASSERT_NEXT(a_start_busy, clk, rst_n, sample_go, busy)
    // the result strobe comes only once the pipeline has drained
    `NTS_ASSERT_SAME(a_result_idle, clk, rst_n, result_valid, !busy)
    // no texture loaded answers magenta
    `NTS_ASSERT_SAME(a_magenta, clk, rst_n,
        result_valid && ((width_reg == '0) || (height_reg == '0)),
        (linear_red == OUT_ONE) && (linear_green == '0) && (linear_blue == OUT_ONE))

endmodule

// ===== sv/nts_texel_ram.sv =====
// ----------------------------------------------------------------------------
// nts_texel_ram
// Texel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nts_texel_ram
    import nts_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TEXEL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [TEXEL_W-1:0] rd_data
);

    logic [TEXEL_W-1:0] mem [STORE_DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/nts_addr_gen.sv =====
// ----------------------------------------------------------------------------
// nts_addr_gen
// Three-stage texel address pipeline: clamp, scale, row-major index.
// ----------------------------------------------------------------------------
module nts_addr_gen
    import nts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_go,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    input  logic [SIDE_W-1:0]         tex_width,
    input  logic [SIDE_W-1:0]         tex_height,
    output nts_ctl_t                  idx_ctl,
    output logic [ADDR_W-1:0]         idx,
    output nts_occ_t                  occ
);

    nts_ctl_t            ctl1_reg, ctl1_next;
    nts_ctl_t            ctl2_reg, ctl2_next;
    nts_ctl_t            ctl3_reg, ctl3_next;
    logic [UNIT_W-1:0]   u_reg, u_next;
    logic [UNIT_W-1:0]   v_reg, v_next;
    logic [POS_W-1:0]    x_reg, x_next;
    logic [POS_W-1:0]    y_reg, y_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic [SIDE_W:0]     scaled_x;
    logic [SIDE_W:0]     scaled_y;
    logic [SIDE_W-1:0]   last_x;
    logic [SIDE_W-1:0]   last_y;
    logic [UNIT_W-1:0]   v_clamp;
    logic [PROD_W-1:0]   row_base;

    // clamp a signed Q15.16 coordinate to zero..one
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [COORD_W-1:0] c);
        logic [UNIT_W-1:0] res;
        if (c[COORD_W-1])
        begin
            res = '0;
        end
        else if (c[COORD_W-2:0] > (COORD_W-1)'(UNIT_ONE))
        begin
            res = UNIT_ONE;
        end
        else
        begin
            res = c[UNIT_W-1:0];
        end
        return res;
    endfunction

    always_comb
    begin
        ctl1_next.valid   = sample_go;
        ctl1_next.magenta = (tex_width == '0) || (tex_height == '0);
        v_clamp           = clamp_unit(coord_v);
        u_next            = sample_go ? clamp_unit(coord_u) : u_reg;
        v_next            = sample_go ? (UNIT_ONE - v_clamp) : v_reg;
    end

    always_comb
    begin
        prod_x    = PROD_W'(u_reg) * PROD_W'(tex_width);
        prod_y    = PROD_W'(v_reg) * PROD_W'(tex_height);
        scaled_x  = prod_x[PROD_W-1:16];
        scaled_y  = prod_y[PROD_W-1:16];
        last_x    = tex_width - SIDE_W'(1);
        last_y    = tex_height - SIDE_W'(1);
        ctl2_next = ctl1_reg;
        x_next    = (scaled_x > (SIDE_W + 1)'(last_x)) ? last_x[POS_W-1:0]
                                                       : scaled_x[POS_W-1:0];
        y_next    = (scaled_y > (SIDE_W + 1)'(last_y)) ? last_y[POS_W-1:0]
                                                       : scaled_y[POS_W-1:0];
    end

    always_comb
    begin
        row_base  = PROD_W'(y_reg) * PROD_W'(tex_width);
        idx_next  = row_base[ADDR_W-1:0] + ADDR_W'(x_reg);
        ctl3_next = ctl2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        idx_reg <= idx_next;
    end

    assign idx_ctl = ctl3_reg;
    assign idx     = idx_reg;
    assign occ     = '{s1: ctl1_reg.valid, s2: ctl2_reg.valid, s3: ctl3_reg.valid};

endmodule

// ===== sv/nts_decode.sv =====
// ----------------------------------------------------------------------------
// nts_decode
// sRGB to linear decode of one texel through the constant table; result strobe.
// ----------------------------------------------------------------------------
module nts_decode
    import nts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  nts_ctl_t           in_ctl,
    input  logic [TEXEL_W-1:0] texel,
    output logic               result_valid,
    output logic [OUT_W-1:0]   linear_red,
    output logic [OUT_W-1:0]   linear_green,
    output logic [OUT_W-1:0]   linear_blue
);

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] red_reg, red_next;
    logic [OUT_W-1:0] green_reg, green_next;
    logic [OUT_W-1:0] blue_reg, blue_next;

    always_comb
    begin
        valid_next = in_ctl.valid;
        if (in_ctl.magenta)
        begin
            red_next   = OUT_ONE;
            green_next = '0;
            blue_next  = OUT_ONE;
        end
        else
        begin
            red_next   = DECODE_LUT[texel[3*CHAN_W-1:2*CHAN_W]];
            green_next = DECODE_LUT[texel[2*CHAN_W-1:CHAN_W]];
            blue_next  = DECODE_LUT[texel[CHAN_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign result_valid = valid_reg;
    assign linear_red   = red_reg;
    assign linear_green = green_reg;
    assign linear_blue  = blue_reg;

endmodule
